// ===== rtl/cubt_pkg.sv =====
// shared types and constants of the chunk undo bitmap tracker
package cubt_pkg;

  localparam int CMD_W = 1;
  localparam int OFF_W = 12;
  localparam int CNT_W = 13;
  localparam int IDX_W = 6;

  localparam logic CMD_SAVE    = 1'b0;
  localparam logic CMD_RESTORE = 1'b1;

  localparam logic DIR_TO_UNDO = 1'b0;
  localparam logic DIR_TO_BASE = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // take the accepted beat, set up pending mask and cursor
    logic step;      // advance the cursor by one chunk
    logic emit;      // write a copy order into the output register
    logic emit_err;  // write a range error beat into the output register
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_err;        // input beat is a save that runs past the buffer
    logic pend_any;      // chunks still pending
    logic hit;           // chunk under the cursor is pending
    logic last;          // chunk under the cursor is the final pending one
    logic out_can_load;  // output register is free this cycle
  } dp_stat_t;

endpackage

// ===== rtl/cubt_if.sv =====
// valid/ready channel interfaces for the input and result beats
interface cubt_in_if import cubt_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [OFF_W-1:0] byte_offset;
  logic [CNT_W-1:0] byte_count;

  modport source (output valid, cmd, byte_offset, byte_count, input ready);
  modport sink (input valid, cmd, byte_offset, byte_count, output ready);
endinterface

interface cubt_out_if import cubt_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] chunk_index;
  logic             copy_direction;
  logic             range_error;
  logic             last_order;

  modport source (output valid, chunk_index, copy_direction, range_error, last_order,
                  input ready);
  modport sink (input valid, chunk_index, copy_direction, range_error, last_order,
                output ready);
endinterface

// ===== rtl/cubt_ctrl.sv =====
// controller state machine of the chunk undo bitmap tracker
module cubt_ctrl import cubt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_ERR  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (stat_i.in_err) begin
            state_d = S_ERR;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (!stat_i.pend_any) begin
          state_d = S_IDLE;
        end else if (!stat_i.hit) begin
          cmd_o.step = 1'b1;
        end else if (stat_i.out_can_load) begin
          cmd_o.emit = 1'b1;
          cmd_o.step = 1'b1;
          if (stat_i.last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (stat_i.out_can_load) begin
          cmd_o.emit_err = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/cubt_dp.sv =====
// datapath: saved chunk map, pending mask, chunk cursor and output register
module cubt_dp import cubt_pkg::*; #(
  parameter int CHUNK_COUNT      = 64,
  parameter int CHUNK_SHIFT_BITS = 6,
  parameter int BUFFER_BYTES     = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output dp_stat_t         stat_o,
  input  logic [CMD_W-1:0] in_cmd_i,
  input  logic [OFF_W-1:0] in_byte_offset_i,
  input  logic [CNT_W-1:0] in_byte_count_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [IDX_W-1:0] out_chunk_index_o,
  output logic             out_copy_direction_o,
  output logic             out_range_error_o,
  output logic             out_last_order_o
);

  localparam int CIW   = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] BufLim = SUM_W'(BUFFER_BYTES);

  logic [CHUNK_COUNT-1:0] map_q, map_d;
  logic [CHUNK_COUNT-1:0] pend_q, pend_d;
  logic [CIW-1:0]         cur_q, cur_d;
  logic                   dir_q, dir_d;

  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       end_byte;
  logic [OFF_W-1:0]       first_chunk;
  logic [SUM_W-1:0]       last_chunk;
  logic                   cnt_nz;
  logic [CHUNK_COUNT-1:0] rng;
  logic [CHUNK_COUNT-1:0] cur_onehot;
  logic                   is_restore;

  logic                   out_valid_q;
  logic [IDX_W-1:0]       idx_q;
  logic                   odir_q;
  logic                   err_q;
  logic                   last_q;

  assign is_restore  = (in_cmd_i == CMD_RESTORE);
  assign cnt_nz      = (in_byte_count_i != '0);
  assign sum         = SUM_W'(in_byte_offset_i) + SUM_W'(in_byte_count_i);
  assign end_byte    = sum - SUM_W'(1);
  assign first_chunk = in_byte_offset_i >> CHUNK_SHIFT_BITS;
  assign last_chunk  = end_byte >> CHUNK_SHIFT_BITS;

  // chunks of the save range that lie inside the map
  always_comb begin
    for (int i = 0; i < CHUNK_COUNT; i++) begin
      rng[i] = cnt_nz && (SUM_W'(i) >= SUM_W'(first_chunk)) && (SUM_W'(i) <= last_chunk);
    end
  end

  assign cur_onehot = CHUNK_COUNT'(1) << cur_q;

  assign stat_o.in_err       = !is_restore && cnt_nz && (sum > BufLim);
  assign stat_o.pend_any     = |pend_q;
  assign stat_o.hit          = pend_q[cur_q];
  assign stat_o.last         = ~|(pend_q & ~cur_onehot);
  assign stat_o.out_can_load = !out_valid_q || out_ready_i;

  always_comb begin
    map_d  = map_q;
    pend_d = pend_q;
    cur_d  = cur_q;
    dir_d  = dir_q;
    if (cmd_i.load) begin
      if (is_restore) begin
        pend_d = map_q;
        map_d  = '0;
        cur_d  = '0;
        dir_d  = DIR_TO_BASE;
      end else begin
        pend_d = rng & ~map_q;
        map_d  = map_q | rng;
        cur_d  = first_chunk[CIW-1:0];
        dir_d  = DIR_TO_UNDO;
      end
    end else begin
      if (cmd_i.emit) begin
        pend_d = pend_q & ~cur_onehot;
      end
      if (cmd_i.step) begin
        cur_d = cur_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q  <= '0;
      pend_q <= '0;
      cur_q  <= '0;
      dir_q  <= DIR_TO_UNDO;
    end else begin
      map_q  <= map_d;
      pend_q <= pend_d;
      cur_q  <= cur_d;
      dir_q  <= dir_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      idx_q  <= IDX_W'(cur_q);
      odir_q <= dir_q;
      err_q  <= 1'b0;
      last_q <= stat_o.last;
    end else if (cmd_i.emit_err) begin
      idx_q  <= '0;
      odir_q <= DIR_TO_UNDO;
      err_q  <= 1'b1;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_chunk_index_o    = idx_q;
  assign out_copy_direction_o = odir_q;
  assign out_range_error_o    = err_q;
  assign out_last_order_o     = last_q;

endmodule

// ===== rtl/chunk_undo_bitmap_tracker_top.sv =====
// top level of the chunk undo bitmap tracker
// timing: an accepted input beat moves the controller to the walk or error state; a copy order
//   is written into the output register once the cursor reaches a pending chunk and the output
//   register is free, and a range error beat once the output register is free
// throughput: one item at a time; a new input beat is taken only in the idle state, after the
//   single cursor has walked up to the last pending chunk; output stalls hold the walk
// reset: asynchronous active low, clears the saved chunk map, the walk and the output valid
module chunk_undo_bitmap_tracker_top import cubt_pkg::*; #(
  parameter int CHUNK_COUNT      = 64,
  parameter int CHUNK_SHIFT_BITS = 6,
  parameter int BUFFER_BYTES     = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  cubt_in_if.sink    in_i,
  cubt_out_if.source out_o
);

  // command and status between controller and datapath
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // controller: idle, walk over pending chunks, or hold a range error beat
  cubt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: the map is updated in full when a beat is loaded; the cursor then walks the pending
  // mask one chunk per cycle, emitting a copy order per hit, and waits on a hit for a free output
  cubt_dp #(
    .CHUNK_COUNT      (CHUNK_COUNT),
    .CHUNK_SHIFT_BITS (CHUNK_SHIFT_BITS),
    .BUFFER_BYTES     (BUFFER_BYTES)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .in_cmd_i             (in_i.cmd),
    .in_byte_offset_i     (in_i.byte_offset),
    .in_byte_count_i      (in_i.byte_count),
    .out_ready_i          (out_o.ready),
    .out_valid_o          (out_o.valid),
    .out_chunk_index_o    (out_o.chunk_index),
    .out_copy_direction_o (out_o.copy_direction),
    .out_range_error_o    (out_o.range_error),
    .out_last_order_o     (out_o.last_order)
  );

endmodule

// ===== rtl/cubt_checker.sv =====
// port level checks of the chunk undo bitmap tracker and their bind
module cubt_checker import cubt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [IDX_W-1:0] out_chunk_index_i,
  input logic             out_copy_direction_i,
  input logic             out_range_error_i,
  input logic             out_last_order_i
);

  // one item at a time: no new beat right after an accepted one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted on two consecutive cycles");

  // an error beat orders no copy and closes its item
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_range_error_i) |->
      (out_last_order_i && out_chunk_index_i == '0 && out_copy_direction_i == DIR_TO_UNDO))
    else $error("malformed range error beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(out_chunk_index_i) && $stable(out_copy_direction_i) &&
       $stable(out_range_error_i) && $stable(out_last_order_i)))
    else $error("result payload changed while stalled");

endmodule

bind chunk_undo_bitmap_tracker_top cubt_checker u_cubt_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_i.valid),
  .in_ready_i           (in_i.ready),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_chunk_index_i    (out_o.chunk_index),
  .out_copy_direction_i (out_o.copy_direction),
  .out_range_error_i    (out_o.range_error),
  .out_last_order_i     (out_o.last_order)
);

// ===== test/chunk_undo_bitmap_tracker_top_test.sv =====
// self-checking testbench of the chunk undo bitmap tracker top level
`timescale 1ns / 1ps

module chunk_undo_bitmap_tracker_top_test import cubt_pkg::*;;

  localparam int CLK_PERIOD  = 8;
  localparam int CHUNKS      = 64;
  localparam int SHIFT       = 6;
  localparam int BUF_BYTES   = 4096;
  localparam int RAND_ITEMS  = 400;
  // long enough for a full restore to walk every chunk, with some slack
  localparam int TAIL_CYCLES = 1 + CHUNKS + 16;
  localparam int TIMEOUT_NS  = 400_000 * CLK_PERIOD;

  // one copy order as the block reports it
  typedef struct packed {
    logic [IDX_W-1:0] chunk_index;
    logic             copy_direction;
    logic             range_error;
    logic             last_order;
  } copy_order_t;

  // tracks the saved chunk map and the copy orders still owed by the block
  class copy_order_board;
    logic [CHUNKS-1:0] saved_map;
    copy_order_t       pending_orders[$];
    int                errors;

    function new();
      saved_map = '0;
      errors    = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // works out the copy orders of one accepted input beat
    function void note_request(logic [CMD_W-1:0] cmd, logic [OFF_W-1:0] off,
                               logic [CNT_W-1:0] cnt);
      int unsigned end_byte;
      int unsigned first_c;
      int unsigned last_c;
      int          owed_before;
      copy_order_t ord;
      owed_before = pending_orders.size();
      end_byte    = int'(off) + int'(cnt);
      if (cmd == CMD_RESTORE) begin
        for (int b = 0; b < CHUNKS; b++) begin
          if (saved_map[b]) begin
            ord = '{chunk_index: IDX_W'(b), copy_direction: DIR_TO_BASE,
                    range_error: 1'b0, last_order: 1'b0};
            pending_orders.push_back(ord);
          end
        end
        saved_map = '0;
      end else if (cnt == '0) begin
        // zero length, nothing happens
      end else if (end_byte > BUF_BYTES) begin
        ord = '{chunk_index: '0, copy_direction: DIR_TO_UNDO,
                range_error: 1'b1, last_order: 1'b1};
        pending_orders.push_back(ord);
      end else begin
        first_c = int'(off) >> SHIFT;
        last_c  = (end_byte - 1) >> SHIFT;
        for (int unsigned b = first_c; b <= last_c && b < CHUNKS; b++) begin
          if (!saved_map[b]) begin
            saved_map[b] = 1'b1;
            ord = '{chunk_index: IDX_W'(b), copy_direction: DIR_TO_UNDO,
                    range_error: 1'b0, last_order: 1'b0};
            pending_orders.push_back(ord);
          end
        end
      end
      if (pending_orders.size() > owed_before)
        pending_orders[pending_orders.size()-1].last_order = 1'b1;
    endfunction

    // compares one accepted result beat with the oldest order owed
    function void check_order(copy_order_t got);
      copy_order_t want;
      if (pending_orders.size() == 0) begin
        report($sformatf("unexpected beat: idx %0d dir %0b err %0b last %0b",
                         got.chunk_index, got.copy_direction, got.range_error,
                         got.last_order));
        return;
      end
      want = pending_orders.pop_front();
      if (got.chunk_index !== want.chunk_index ||
          got.copy_direction !== want.copy_direction ||
          got.range_error !== want.range_error ||
          got.last_order !== want.last_order)
        report($sformatf({"mismatch: expected idx %0d dir %0b err %0b last %0b,",
                          " got idx %0d dir %0b err %0b last %0b"},
                         want.chunk_index, want.copy_direction, want.range_error,
                         want.last_order, got.chunk_index, got.copy_direction,
                         got.range_error, got.last_order));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  // while set neither side idles
  bit   calm = 1'b0;

  copy_order_board board = new();

  cubt_in_if  in_if();
  cubt_out_if out_if();

  chunk_undo_bitmap_tracker_top #(
    .CHUNK_COUNT     (CHUNKS),
    .CHUNK_SHIFT_BITS(SHIFT),
    .BUFFER_BYTES    (BUF_BYTES)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // either side is idle with a chance of about 15 in a hundred, except in the calm stretch
  function automatic bit idle_now();
    return !calm && $urandom_range(0, 99) < 15;
  endfunction

  // result side: random back pressure
  always @(posedge clk_i) begin
    out_if.ready <= !idle_now();
  end

  // result monitor: every accepted beat is checked against the oldest owed order
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      board.check_order('{chunk_index: out_if.chunk_index,
                          copy_direction: out_if.copy_direction,
                          range_error: out_if.range_error,
                          last_order: out_if.last_order});
  end

  // presents one input beat, with a random gap in front, and waits for it to be taken
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [OFF_W-1:0] off,
                           input logic [CNT_W-1:0] cnt);
    while (idle_now()) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.byte_offset <= off;
    in_if.byte_count  <= cnt;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_request(cmd, off, cnt);
  endtask

  // restore carries random offset and count, which the block must ignore
  task automatic send_restore();
    send_item(CMD_RESTORE, OFF_W'($urandom), CNT_W'($urandom));
  endtask

  // holds the sender back until every owed order has come out
  task automatic drain_orders();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending_orders.size() != 0);
  endtask

  // one random item: mostly in-range saves of a few chunks, some restores,
  // some zero-length saves and some ranges past the end of the buffer
  task automatic send_random_item();
    int unsigned pick;
    int unsigned off;
    int unsigned cnt;
    pick = $urandom_range(0, 99);
    off  = $urandom_range(0, BUF_BYTES - 1);
    if (pick < 12) begin
      send_restore();
    end else if (pick < 16) begin
      send_item(CMD_SAVE, OFF_W'(off), '0);
    end else if (pick < 22) begin
      cnt = $urandom_range(BUF_BYTES + 1 - off, (1 << CNT_W) - 1);
      send_item(CMD_SAVE, OFF_W'(off), CNT_W'(cnt));
    end else begin
      // mostly a handful of chunks, now and then up to the whole buffer
      if ($urandom_range(0, 99) < 85) cnt = $urandom_range(1, 5 * 64);
      else cnt = $urandom_range(1, BUF_BYTES);
      if (off + cnt > BUF_BYTES) cnt = BUF_BYTES - off;
      send_item(CMD_SAVE, OFF_W'(off), CNT_W'(cnt));
    end
  endtask

  initial begin
    in_if.valid       <= 1'b0;
    in_if.cmd         <= CMD_SAVE;
    in_if.byte_offset <= '0;
    in_if.byte_count  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_restore();                                // restore with nothing saved
    send_item(CMD_SAVE, 12'd4095, 13'd0);          // zero length at the top offset
    send_item(CMD_SAVE, 12'd0, 13'd4096);          // whole buffer, all 64 chunks
    send_item(CMD_SAVE, 12'd0, 13'd4096);          // every chunk already saved
    send_item(CMD_SAVE, 12'd100, 13'd1);           // single byte in a saved chunk
    send_item(CMD_RESTORE, 12'd4095, 13'd8191);    // full restore, fields at maximum
    send_item(CMD_SAVE, 12'd4095, 13'd1);          // last byte of the buffer
    send_item(CMD_SAVE, 12'd4095, 13'd2);          // one byte past the end
    send_item(CMD_SAVE, 12'd1, 13'd4096);          // whole length, shifted by one
    send_item(CMD_SAVE, 12'd0, 13'd8191);          // largest count
    send_item(CMD_SAVE, 12'd4095, 13'd8191);       // largest offset and count
    send_item(CMD_SAVE, 12'd63, 13'd2);            // straddles chunks 0 and 1
    send_item(CMD_SAVE, 12'd64, 13'd64);           // chunk 1 already saved
    send_item(CMD_SAVE, 12'hAAA, 13'h0555);        // alternating bits, last byte is 4094
    send_item(CMD_SAVE, 12'h555, 13'h0AAA);        // the other bit pattern
    send_restore();
    send_restore();                                // empty restore after a restore
    send_item(CMD_SAVE, 12'd0, 13'd64);            // exactly chunk 0
    send_item(CMD_SAVE, 12'd4032, 13'd64);         // exactly chunk 63, ends at the buffer end
    send_item(CMD_SAVE, 12'd2048, 13'd2048);       // upper half
    send_restore();

    // sender waits for the block to run dry once before the random part
    drain_orders();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= 200 && i < 280);
      if (i == 120) drain_orders();
      send_random_item();
    end
    calm = 1'b0;

    // wait for the owed orders, then for anything stray the block might still emit
    drain_orders();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.pending_orders.size() != 0)
      board.report($sformatf("%0d orders never arrived", board.pending_orders.size()));

    if (board.errors == 0) begin
      $display("chunk_undo_bitmap_tracker_top test passed");
    end else begin
      $display("chunk_undo_bitmap_tracker_top test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("chunk_undo_bitmap_tracker_top test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cubt_pkg.sv
rtl/cubt_if.sv
rtl/cubt_ctrl.sv
rtl/cubt_dp.sv
rtl/chunk_undo_bitmap_tracker_top.sv
rtl/cubt_checker.sv
test/chunk_undo_bitmap_tracker_top_test.sv
